FILE: hdl/ccf_pkg.sv
// Shared types, character codes and mode codes for the comment and continuation filter.
`timescale 1ns / 1ps

package ccf_pkg;

    // Default counter widths
    localparam int LINE_BITS_DEF   = 32;
    localparam int COLUMN_BITS_DEF = 16;

    // Widths of the delivered position fields
    localparam int OUT_LINE_W   = 32;
    localparam int OUT_COLUMN_W = 16;

    // Filtered item: bit 8 marks end of stream, low byte is the character
    typedef logic [8:0] item_t;

    localparam item_t ITEM_NONE = 9'h000;
    localparam item_t ITEM_END  = 9'h100;

    // Characters the filter reacts to
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    // Comment mode codes
    localparam logic [2:0] CM_NONE  = 3'd0;  // outside any comment
    localparam logic [2:0] CM_SLASH = 3'd1;  // one slash held back
    localparam logic [2:0] CM_LINE  = 3'd2;  // inside a line comment
    localparam logic [2:0] CM_BLOCK = 3'd3;  // inside a block comment
    localparam logic [2:0] CM_STAR  = 3'd4;  // block comment, star just seen

    // Continuation mode codes
    localparam logic [2:0] CT_NONE  = 3'd0;  // nothing pending
    localparam logic [2:0] CT_BSL   = 3'd1;  // backslash held back
    localparam logic [2:0] CT_BLANK = 3'd2;  // blanks after the backslash
    localparam logic [2:0] CT_NEWLN = 3'd3;  // line joined
    localparam logic [2:0] CT_FLUSH = 3'd4;  // pass the next character through

    // Character literal tracking codes (signed); other negative values count up to none
    localparam logic signed [2:0] QM_NONE  = 3'sd0;
    localparam logic signed [2:0] QM_OPEN  = 3'sd1;
    localparam logic signed [2:0] QM_ESC   = -3'sd4;
    localparam logic signed [2:0] QM_CLOSE = -3'sd1;

    // Input item
    typedef struct packed {
        logic [7:0] in_char;
        logic       in_end;
    } byte_t;

    // Result item
    typedef struct packed {
        logic [7:0]              out_char;
        logic                    out_end;
        logic [OUT_LINE_W-1:0]   out_line;
        logic [OUT_COLUMN_W-1:0] out_column;
        logic                    out_last;
    } char_t;

    // Lexical modes of the filter
    typedef struct packed {
        logic [2:0]        comment;
        logic [2:0]        cont;
        logic              in_string;
        logic signed [2:0] quote;
    } mode_t;

    // Position bookkeeping request for dropped text
    typedef struct packed {
        logic       en;
        logic       line;
        logic [1:0] cols;
    } skip_t;

    // Delivery request to the position tracker
    typedef struct packed {
        logic  en;
        item_t item;
    } del_t;

    // Outcome of filtering one byte
    typedef struct packed {
        mode_t      mode_next;
        item_t      first;
        item_t      second;
        logic       has_first;
        logic       has_second;
        logic       skip_line;
        logic [1:0] skip_cols;
    } flt_t;

endpackage

FILE: hdl/ccf_filter.sv
// Mode logic: filters one byte through up to two passes and lists the characters it releases.
`timescale 1ns / 1ps

module ccf_filter (
    input  ccf_pkg::mode_t mode,
    input  ccf_pkg::byte_t data,
    output ccf_pkg::flt_t  result
);
    import ccf_pkg::*;

    typedef struct packed {
        mode_t      mode;
        item_t      item;
        logic [7:0] held;
        logic [1:0] skip_cols;
        logic       skip_line;
    } pass_t;

    // One pass of the filter on one event
    function automatic pass_t run_pass(input mode_t m, input logic is_end,
                                       input logic [7:0] ev);
        pass_t r;
        r.mode      = m;
        r.item      = ITEM_NONE;
        r.held      = 8'h00;
        r.skip_cols = 2'd0;
        r.skip_line = 1'b0;
        if (is_end) begin
            r.item = ITEM_END;
        end else if (m.comment != CM_NONE) begin
            if (ev == CH_SLASH) begin
                if (m.comment == CM_SLASH) begin
                    r.mode.comment = CM_LINE;
                    r.skip_cols    = 2'd2;
                end else begin
                    if (m.comment == CM_STAR) r.mode.comment = CM_NONE;
                    r.skip_cols = 2'd1;
                end
            end else if (ev == CH_NL) begin
                if (m.comment == CM_SLASH) begin
                    r.mode.comment = CM_NONE;
                    r.item         = {1'b0, CH_SLASH};
                    r.held         = CH_NL;
                end else if (m.comment == CM_LINE) begin
                    r.mode.comment = CM_NONE;
                    r.item         = {1'b0, CH_NL};
                end else begin
                    if (m.comment == CM_STAR) r.mode.comment = CM_BLOCK;
                    r.skip_line = 1'b1;
                end
            end else if (ev == CH_STAR) begin
                if (m.comment == CM_SLASH) begin
                    r.mode.comment = CM_BLOCK;
                    r.skip_cols    = 2'd2;
                end else begin
                    if (m.comment == CM_BLOCK) r.mode.comment = CM_STAR;
                    else if (m.comment == CM_STAR) r.mode.comment = CM_BLOCK;
                    r.skip_cols = 2'd1;
                end
            end else begin
                if (m.comment == CM_SLASH) begin
                    r.mode.comment = CM_NONE;
                    r.item         = {1'b0, CH_SLASH};
                    r.held         = ev;
                end else begin
                    if (m.comment == CM_STAR) r.mode.comment = CM_BLOCK;
                    r.skip_cols = 2'd1;
                end
            end
        end else if (m.cont != CT_NONE) begin
            if (m.cont == CT_FLUSH) begin
                r.mode.cont = CT_NONE;
                r.item      = {1'b0, ev};
            end else if (ev == CH_SPACE || ev == CH_TAB) begin
                if (m.cont == CT_BSL) begin
                    r.mode.cont = CT_BLANK;
                    r.skip_cols = 2'd2;
                end else begin
                    r.skip_cols = 2'd1;
                end
            end else if (ev == CH_BSL) begin
                if (m.cont == CT_BSL) begin
                    r.mode.cont = CT_FLUSH;
                    r.item      = {1'b0, CH_BSL};
                    r.held      = CH_BSL;
                end else begin
                    r.mode.cont = CT_BSL;
                end
            end else if (ev == CH_NL) begin
                if (m.cont == CT_NEWLN) begin
                    r.mode.cont = CT_NONE;
                    r.item      = {1'b0, CH_NL};
                end else begin
                    r.mode.cont = CT_NEWLN;
                    r.skip_line = 1'b1;
                end
            end else begin
                if (m.cont == CT_BSL) begin
                    r.mode.cont = CT_FLUSH;
                    r.item      = {1'b0, CH_BSL};
                    r.held      = ev;
                end else begin
                    r.mode.cont = CT_NONE;
                    r.held      = ev;
                end
            end
        end else if (ev == CH_BSL) begin
            if (m.quote == QM_NONE) begin
                r.mode.cont = CT_BSL;
            end else if (m.quote == QM_OPEN) begin
                r.mode.quote = QM_ESC;
                r.item       = {1'b0, ev};
            end else if (m.quote == QM_ESC) begin
                r.mode.quote = QM_CLOSE;
                r.item       = {1'b0, ev};
            end else begin
                r.mode.quote = QM_NONE;
                r.mode.cont  = CT_BSL;
                r.item       = {1'b0, ev};
            end
        end else if (ev == CH_DQUOTE) begin
            r.item = {1'b0, ev};
            if (m.quote == QM_NONE) begin
                r.mode.in_string = ~m.in_string;
            end else if (m.quote == QM_OPEN || m.quote == QM_ESC) begin
                r.mode.quote = QM_CLOSE;
            end else begin
                r.mode.quote     = QM_NONE;
                r.mode.in_string = ~m.in_string;
            end
        end else if (ev == CH_SQUOTE) begin
            r.item = {1'b0, ev};
            if (m.quote == QM_NONE) begin
                if (!m.in_string) r.mode.quote = QM_OPEN;
            end else if (m.quote == QM_ESC) begin
                r.mode.quote = QM_CLOSE;
            end else begin
                r.mode.quote = QM_NONE;
            end
        end else if (ev == CH_SLASH) begin
            if (m.quote == QM_NONE) begin
                if (!m.in_string) r.mode.comment = CM_SLASH;
                else r.item = {1'b0, ev};
            end else if (m.quote == QM_OPEN) begin
                r.mode.quote = QM_CLOSE;
                r.item       = {1'b0, ev};
            end else begin
                r.mode.quote = QM_NONE;
                r.item       = {1'b0, ev};
            end
        end else begin
            r.item = {1'b0, ev};
            if (ev == CH_NL) r.mode.quote = QM_NONE;
            else if (m.quote == QM_OPEN) r.mode.quote = QM_CLOSE;
            else if (m.quote == QM_ESC && ev != CH_X) r.mode.quote = QM_CLOSE;
            else if (m.quote != QM_NONE) r.mode.quote = m.quote + 3'sd1;
        end
        return r;
    endfunction

    pass_t p1;
    pass_t p2;
    logic  held_live;
    item_t item_a;
    item_t item_b;

    // First pass on the byte, second pass on a character it hands back
    assign p1        = run_pass(mode, data.in_end, data.in_char);
    assign p2        = run_pass(p1.mode, 1'b0, p1.held);
    assign held_live = (p1.held != 8'h00);
    assign item_a    = p1.item;
    assign item_b    = held_live ? p2.item : ITEM_NONE;

    // Pack released characters in order; the second pass never drops text
    always_comb
    begin
        result.mode_next  = held_live ? p2.mode : p1.mode;
        result.skip_line  = p1.skip_line;
        result.skip_cols  = p1.skip_cols;
        result.has_first  = (item_a != ITEM_NONE) || (item_b != ITEM_NONE);
        result.has_second = (item_a != ITEM_NONE) && (item_b != ITEM_NONE);
        result.first      = (item_a != ITEM_NONE) ? item_a : item_b;
        result.second     = item_b;
    end

endmodule

FILE: hdl/ccf_position.sv
// Line and column tracker: counts dropped text and stamps each delivered character.
`timescale 1ns / 1ps

module ccf_position #(
    parameter int LINE_BITS   = ccf_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS = ccf_pkg::COLUMN_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ccf_pkg::skip_t         skip,
    input  ccf_pkg::del_t          del,
    output logic [LINE_BITS-1:0]   line,
    output logic [COLUMN_BITS-1:0] column
);
    import ccf_pkg::*;

    localparam int LSUM_W = LINE_BITS + 2;
    localparam int CSUM_W = COLUMN_BITS + 2;

    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [COLUMN_BITS-1:0] col_reg, col_next;
    logic [LINE_BITS-1:0]   sk_lines_reg, sk_lines_next;
    logic [COLUMN_BITS-1:0] sk_cols_reg, sk_cols_next;
    logic                   last_nl_reg, last_nl_next;

    logic [LSUM_W-1:0]      line_sum;
    logic [CSUM_W-1:0]      col_sum;
    logic [COLUMN_BITS-1:0] col_base;
    logic [COLUMN_BITS-1:0] col_add;
    logic                   has_lines;
    logic                   item_nl;
    logic                   col_inc;
    logic [LINE_BITS:0]     sk_line_sum;
    logic [COLUMN_BITS:0]   sk_col_sum;
    logic [LINE_BITS-1:0]   sk_line_sat;
    logic [COLUMN_BITS-1:0] sk_col_sat;

    // Position of the character being delivered, saturating
    always_comb
    begin
        has_lines = (sk_lines_reg != '0);
        item_nl   = (del.item == {1'b0, CH_NL});
        col_inc   = !(del.item[8] || item_nl);
        line_sum  = {2'b00, line_reg} + {2'b00, sk_lines_reg} + LSUM_W'(last_nl_reg);
        line_next = (line_sum[LSUM_W-1:LINE_BITS] != 2'b00) ? '1 : line_sum[LINE_BITS-1:0];
        col_base  = has_lines ? sk_cols_reg : (last_nl_reg ? '0 : col_reg);
        col_add   = has_lines ? '0 : sk_cols_reg;
        col_sum   = {2'b00, col_base} + {2'b00, col_add} + CSUM_W'(col_inc);
        col_next  = (col_sum[CSUM_W-1:COLUMN_BITS] != 2'b00) ? '1 : col_sum[COLUMN_BITS-1:0];
    end

    // Advance the dropped-text counts, saturating
    always_comb
    begin
        sk_line_sum = {1'b0, sk_lines_reg} + (LINE_BITS+1)'(1);
        sk_col_sum  = {1'b0, sk_cols_reg} + (COLUMN_BITS+1)'(skip.cols);
        sk_line_sat = sk_line_sum[LINE_BITS] ? '1 : sk_line_sum[LINE_BITS-1:0];
        sk_col_sat  = sk_col_sum[COLUMN_BITS] ? '1 : sk_col_sum[COLUMN_BITS-1:0];

        sk_lines_next = sk_lines_reg;
        sk_cols_next  = sk_cols_reg;
        last_nl_next  = last_nl_reg;
        if (del.en) begin
            sk_lines_next = '0;
            sk_cols_next  = '0;
            last_nl_next  = item_nl;
        end else if (skip.en) begin
            if (skip.line) begin
                sk_lines_next = sk_line_sat;
                sk_cols_next  = '0;
            end else begin
                sk_cols_next = sk_col_sat;
            end
        end
    end

    // Hold position state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg     <= LINE_BITS'(1);
            col_reg      <= '0;
            sk_lines_reg <= '0;
            sk_cols_reg  <= '0;
            last_nl_reg  <= 1'b0;
        end
        else
        begin
            if (del.en)
            begin
                line_reg <= line_next;
                col_reg  <= col_next;
            end
            sk_lines_reg <= sk_lines_next;
            sk_cols_reg  <= sk_cols_next;
            last_nl_reg  <= last_nl_next;
        end
    end

    assign line   = line_next;
    assign column = col_next;

endmodule

FILE: hdl/comment_and_continuation_filter.sv
// Top level of the comment and continuation filter.
// Takes one source byte (or the end marker) per cycle while byte_ready is high and delivers
// the text with line and block comments removed and backslash continuations joined, each
// character stamped with its saturating line and column. A byte goes from the input register
// through the mode logic and the position tracker into the output register, so the block
// keeps pace at one byte per cycle while the output is not stalled; a byte that releases two
// characters (a held-back slash or backslash followed by its successor) sends the second
// character from a one-entry hold register while the input waits. Dropped bytes use no output
// slot. The last character of each byte carries out_last. No clearing pass follows reset.
`timescale 1ns / 1ps

module comment_and_continuation_filter #(
    parameter int LINE_BITS   = ccf_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS = ccf_pkg::COLUMN_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           byte_valid,
    output logic           byte_ready,
    input  ccf_pkg::byte_t byte_data,
    output logic           char_valid,
    input  logic           char_ready,
    output ccf_pkg::char_t char_data
);
    import ccf_pkg::*;

    logic   in_v_reg;
    byte_t  in_reg;
    mode_t  mode_reg;
    logic   pend_v_reg;
    item_t  pend_reg;
    logic   out_v_reg;
    char_t  out_reg, out_next;

    flt_t   flt;
    skip_t  skip_req;
    del_t   del_req;
    logic   out_free;
    logic   fire;
    logic   pend_fire;
    logic   del_last;
    logic [LINE_BITS-1:0]   pos_line;
    logic [COLUMN_BITS-1:0] pos_col;

    ccf_filter u_filter (
        .mode   (mode_reg),
        .data   (in_reg),
        .result (flt)
    );

    ccf_position #(
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_position (
        .clk    (clk),
        .rst_n  (rst_n),
        .skip   (skip_req),
        .del    (del_req),
        .line   (pos_line),
        .column (pos_col)
    );

    // Handshake and issue control
    always_comb
    begin
        out_free   = !out_v_reg || char_ready;
        fire       = in_v_reg && !pend_v_reg && (out_free || !flt.has_first);
        pend_fire  = pend_v_reg && out_free;
        byte_ready = !in_v_reg || fire;

        skip_req.en   = fire && !flt.has_first;
        skip_req.line = flt.skip_line;
        skip_req.cols = flt.skip_cols;

        del_req.en   = pend_fire || (fire && flt.has_first);
        del_req.item = pend_v_reg ? pend_reg : flt.first;
        del_last     = pend_v_reg || !flt.has_second;
    end

    // Build the result item
    always_comb
    begin
        out_next.out_char   = del_req.item[8] ? 8'h00 : del_req.item[7:0];
        out_next.out_end    = del_req.item[8];
        out_next.out_line   = OUT_LINE_W'(pos_line);
        out_next.out_column = OUT_COLUMN_W'(pos_col);
        out_next.out_last   = del_last;
    end

    // Input register, modes, hold register and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg   <= 1'b0;
            mode_reg   <= '0;
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            if (byte_valid && byte_ready)
            begin
                in_v_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_v_reg <= 1'b0;
            end

            if (fire)
            begin
                mode_reg <= flt.mode_next;
            end

            if (fire && flt.has_second)
            begin
                pend_v_reg <= 1'b1;
            end
            else if (pend_fire)
            begin
                pend_v_reg <= 1'b0;
            end

            if (del_req.en)
            begin
                out_v_reg <= 1'b1;
            end
            else if (char_ready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
        begin
            in_reg <= byte_data;
        end
        if (fire && flt.has_second)
        begin
            pend_reg <= flt.second;
        end
        if (del_req.en)
        begin
            out_reg <= out_next;
        end
    end

    assign char_valid = out_v_reg;
    assign char_data  = out_reg;

endmodule
